[rtl/core/owned_id_allocator_unit_macros.svh]
// Assertion macros shared by the owned ID allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef OWNED_ID_ALLOCATOR_UNIT_MACROS_SVH
`define OWNED_ID_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define OIA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/oia_pkg.sv]
// Package for the owned ID allocator: defaults, field widths, action codes.
// No dependencies; used by the top level and the checker.
package oia_pkg;

	localparam int unsigned DefNumIds    = 128;
	localparam int unsigned DefFirstId   = 1;
	localparam int unsigned DefOwnerBits = 16;
	localparam int unsigned DefMaxBurst  = 64;

	// fixed stream field widths
	localparam int unsigned ActW     = 3;
	localparam int unsigned OwnerW   = 16;
	localparam int unsigned IdW      = 8;
	localparam int unsigned CountW   = 7;
	localparam int unsigned NumOutW  = 8;
	localparam int unsigned InDataW  = 32;
	localparam int unsigned OutDataW = 48;

	// actions
	localparam logic [ActW-1:0] ACT_ALLOC_ONE   = 3'd0;
	localparam logic [ActW-1:0] ACT_ALLOC_CNT   = 3'd1;
	localparam logic [ActW-1:0] ACT_ALLOC_GIVEN = 3'd2;
	localparam logic [ActW-1:0] ACT_RELEASE     = 3'd3;
	localparam logic [ActW-1:0] ACT_RELEASE_ALL = 3'd4;
	localparam logic [ActW-1:0] ACT_OWNER_QUERY = 3'd5;
	localparam logic [ActW-1:0] ACT_FREE_QUERY  = 3'd6;
	localparam logic [ActW-1:0] ACT_CLEAR       = 3'd7;

endpackage

[rtl/core/owned_id_allocator_unit.sv]
// Owned ID allocator: pool of NUM_IDS IDs, each free or owned by an owner number.
// Depends on oia_pkg and oia_owner_ram.
//
// Usage
//   Input stream (s_*): one transfer per request. s_tuser carries the action,
//   s_tdata the owner, requested ID and burst count. Output stream (m_*): one
//   transfer per result, m_tlast marks the final result of a request. A burst
//   allocation yields one result per granted ID; every other request one.
//   s_tready is high only while no request is in progress.
// Sequencing
//   Single-entry actions and failed allocations: one result, loaded from the
//   decode state. Alloc one / alloc count: a walk from entry 0 loads one result
//   per granted ID, taking the lowest free entries in order of table index.
//   Release all: the owner table is swept one entry per cycle through its
//   registered read port, then the count of released IDs is loaded.
//   The next request is taken the cycle after the last result is loaded.
// Reset
//   arst_n clears the sequencer, the output valid and the free map (all IDs
//   free, free count NUM_IDS). The owner table is not cleared: an entry is
//   read only while its ID is owned, so it is always written before use.
// Backpressure
//   The output register holds a result until m_tready; the walk pauses on a
//   free entry until the register can take its result.
module owned_id_allocator_unit
	import oia_pkg::*;
#(
	parameter int unsigned NUM_IDS    = DefNumIds,
	parameter int unsigned FIRST_ID   = DefFirstId,
	parameter int unsigned OWNER_BITS = DefOwnerBits,
	parameter int unsigned MAX_BURST  = DefMaxBurst
) (
	input  logic                clk,
	input  logic                arst_n,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // owner[15:0], req_id[23:16], count[30:24], pad
	input  logic [ActW-1:0]     s_tuser,   // action[2:0]
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // ok[0], grant_id[8:1], owner_res[24:9],
	                                       // released[32:25], free_count[40:33], pad
	output logic                m_tlast    // last
);

	localparam int unsigned IdxW = $clog2(NUM_IDS);
	localparam int unsigned PtrW = $clog2(NUM_IDS + 1);
	localparam int unsigned GntW = $clog2(MAX_BURST + 1);
	localparam int unsigned OwnW = (OWNER_BITS < OwnerW) ? OWNER_BITS : OwnerW;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DISP   = 3'd1; // decode, single-entry actions
	localparam logic [2:0] ST_SCAN   = 3'd2; // lowest-free walk for allocations
	localparam logic [2:0] ST_RELALL = 3'd3; // owner table sweep
	localparam logic [2:0] ST_FIN    = 3'd4; // release-all result

	logic [2:0]        state_q, state_nx;
	logic [ActW-1:0]   act_q;
	logic [OwnW-1:0]   who_q;
	logic [IdxW-1:0]   idx_q;
	logic              inr_q;
	logic [CountW-1:0] cnt_q;
	logic [PtrW-1:0]   ptr_q;
	logic [GntW-1:0]   rem_q;
	logic [PtrW-1:0]   rel_q;
	logic [PtrW-1:0]   ftot_q, ftot_nx;
	logic [NUM_IDS-1:0] free_q;
	logic              vld_s1;
	logic [IdxW-1:0]   ptr_s1;

	logic                m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;
	logic                m_tlast_q;

	// input fields
	logic [OwnerW-1:0] in_owner;
	logic [IdW-1:0]    in_sid, in_diff;
	logic [CountW-1:0] in_cnt;
	logic              in_inr;
	logic              accept;

	// owner table
	logic            ram_we;
	logic [IdxW-1:0] ram_waddr, ram_raddr;
	logic [OwnW-1:0] rd_data;

	// datapath
	logic              out_free;
	logic              own_match, idx_free, scan_free, rel_hit;
	logic [IdxW-1:0]   scan_idx;
	logic [CountW-1:0] cap, want;
	logic [GntW-1:0]   gnt;
	logic              emit, e_ok, e_last;
	logic [IdW-1:0]    e_id;
	logic [OwnerW-1:0] e_own;
	logic [NumOutW-1:0] e_rel;
	logic              fm_clr, fm_set, fm_all;
	logic [IdxW-1:0]   fm_clr_idx, fm_set_idx;

	assign in_owner = s_tdata[15:0];
	assign in_sid   = s_tdata[23:16];
	assign in_cnt   = s_tdata[30:24];
	assign in_diff  = in_sid - IdW'(FIRST_ID);
	assign in_inr   = {1'b0, in_diff} < (IdW + 1)'(NUM_IDS);
	assign accept   = s_tvalid && s_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign out_free  = !m_tvalid_q || m_tready;
	assign own_match = (rd_data == who_q);
	assign idx_free  = inr_q && free_q[idx_q];
	assign scan_idx  = ptr_q[IdxW-1:0];
	assign scan_free = free_q[scan_idx];
	assign rel_hit   = vld_s1 && !free_q[ptr_s1] && own_match;

	// burst size: capped count, limited by what is left in the pool
	assign cap  = (cnt_q > CountW'(MAX_BURST)) ? CountW'(MAX_BURST) : cnt_q;
	assign want = (act_q == ACT_ALLOC_ONE) ? CountW'(1) : cap;
	assign gnt  = ({2'b0, want} < 9'(ftot_q)) ? GntW'(want) : GntW'(ftot_q);

	// read address: request ID at accept, sweep pointer during release all
	always_comb begin
		unique case (state_q)
			ST_IDLE:   ram_raddr = in_inr ? in_diff[IdxW-1:0] : '0;
			ST_RELALL: ram_raddr = (ptr_q < PtrW'(NUM_IDS)) ? ptr_q[IdxW-1:0] : '0;
			default:   ram_raddr = idx_q;
		endcase
	end

	always_comb begin
		state_nx   = state_q;
		ftot_nx    = ftot_q;
		emit       = 1'b0;
		e_ok       = 1'b0;
		e_last     = 1'b1;
		e_id       = '0;
		e_own      = '0;
		e_rel      = '0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		fm_clr     = 1'b0;
		fm_clr_idx = idx_q;
		fm_set     = 1'b0;
		fm_set_idx = idx_q;
		fm_all     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_DISP;
				end
			end
			ST_DISP: begin
				case (act_q) inside
					ACT_ALLOC_ONE, ACT_ALLOC_CNT: begin
						if (gnt != '0) begin
							ftot_nx  = ftot_q - PtrW'(gnt);
							state_nx = ST_SCAN;
						end else if (out_free) begin
							emit     = 1'b1;
							state_nx = ST_IDLE;
						end
					end
					ACT_RELEASE_ALL: begin
						state_nx = ST_RELALL;
					end
					default: begin
						if (out_free) begin
							emit     = 1'b1;
							state_nx = ST_IDLE;
							case (act_q)
								ACT_ALLOC_GIVEN: begin
									if (idx_free) begin
										e_ok    = 1'b1;
										e_id    = IdW'(idx_q) + IdW'(FIRST_ID);
										ram_we  = 1'b1;
										fm_clr  = 1'b1;
										ftot_nx = ftot_q - PtrW'(1);
									end
								end
								ACT_RELEASE: begin
									if (inr_q && !free_q[idx_q] && own_match) begin
										e_ok    = 1'b1;
										fm_set  = 1'b1;
										ftot_nx = ftot_q + PtrW'(1);
									end
								end
								ACT_OWNER_QUERY: begin
									if (inr_q && !free_q[idx_q]) begin
										e_ok  = own_match;
										e_own = OwnerW'(rd_data);
									end
								end
								ACT_FREE_QUERY: begin
									e_ok = idx_free;
								end
								default: begin // clear
									e_ok    = 1'b1;
									fm_all  = 1'b1;
									ftot_nx = PtrW'(NUM_IDS);
								end
							endcase
						end
					end
				endcase
			end
			ST_SCAN: begin
				if (scan_free && out_free) begin
					emit       = 1'b1;
					e_ok       = 1'b1;
					e_id       = IdW'(scan_idx) + IdW'(FIRST_ID);
					e_last     = (rem_q == GntW'(1));
					ram_we     = 1'b1;
					ram_waddr  = scan_idx;
					fm_clr     = 1'b1;
					fm_clr_idx = scan_idx;
					if (rem_q == GntW'(1)) begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_RELALL: begin
				if (rel_hit) begin
					fm_set     = 1'b1;
					fm_set_idx = ptr_s1;
					ftot_nx    = ftot_q + PtrW'(1);
				end
				if (ptr_q == PtrW'(NUM_IDS)) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					emit     = 1'b1;
					e_ok     = (rel_q != '0);
					e_rel    = NumOutW'(rel_q);
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer and free map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ftot_q  <= PtrW'(NUM_IDS);
			free_q  <= '1;
			vld_s1  <= 1'b0;
			ptr_q   <= '0;
			rem_q   <= '0;
			rel_q   <= '0;
		end else begin
			state_q <= state_nx;
			ftot_q  <= ftot_nx;
			if (fm_all) begin
				free_q <= '1;
			end else begin
				if (fm_clr) begin
					free_q[fm_clr_idx] <= 1'b0;
				end
				if (fm_set) begin
					free_q[fm_set_idx] <= 1'b1;
				end
			end
			vld_s1 <= (state_q == ST_RELALL) && (ptr_q < PtrW'(NUM_IDS));
			unique case (state_q)
				ST_DISP: begin
					ptr_q <= '0;
					rel_q <= '0;
					rem_q <= gnt;
				end
				ST_SCAN: begin
					if (!scan_free) begin
						ptr_q <= ptr_q + PtrW'(1);
					end else if (out_free) begin
						ptr_q <= ptr_q + PtrW'(1);
						rem_q <= rem_q - GntW'(1);
					end
				end
				ST_RELALL: begin
					if (ptr_q < PtrW'(NUM_IDS)) begin
						ptr_q <= ptr_q + PtrW'(1);
					end
					if (rel_hit) begin
						rel_q <= rel_q + PtrW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request fields, held for the whole request
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_tuser;
			who_q <= in_owner[OwnW-1:0];
			idx_q <= in_inr ? in_diff[IdxW-1:0] : '0;
			inr_q <= in_inr;
			cnt_q <= in_cnt;
		end
		ptr_s1 <= ptr_q[IdxW-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {7'b0, NumOutW'(ftot_nx), e_rel, e_own, e_id, e_ok};
			m_tlast_q <= e_last;
		end
	end

	oia_owner_ram #(
		.DEPTH (NUM_IDS),
		.AW    (IdxW),
		.DW    (OwnW)
	) u_owner_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (who_q),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

endmodule

[rtl/core/oia_owner_ram.sv]
// Owner table storage: one write port, one registered read port.
// No dependencies; instantiated by owned_id_allocator_unit.
module oia_owner_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7,
	parameter int unsigned DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/oia_checker.sv]
// Port-level checker for the owned ID allocator, bound to the top level.
// Depends on oia_pkg and owned_id_allocator_unit_macros.svh.
`include "owned_id_allocator_unit_macros.svh"

module oia_checker
	import oia_pkg::*;
#(
	parameter int unsigned NUM_IDS = DefNumIds
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                m_tlast
);

	// a stalled result transfer holds
	`OIA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// one request at a time: busy right after a request transfer
	`OIA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// a failed result always closes its request
	`OIA_ASSERT_IMPL(a_fail_is_last, clk, arst_n, m_tvalid && !m_tdata[0], m_tlast, "failed result without last")

	// free count never exceeds the pool size
	`OIA_ASSERT_IMPL(a_free_bound, clk, arst_n, m_tvalid, m_tdata[40:33] <= NumOutW'(NUM_IDS), "free count above pool size")

endmodule

bind owned_id_allocator_unit oia_checker #(
	.NUM_IDS (NUM_IDS)
) u_oia_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
